### src/tlc_pkg.sv
// Shared types, codes and helpers for the two-road traffic light controller.
`timescale 1ns / 1ps
`default_nettype none

package tlc_pkg;

  // Tick period in milliseconds
  localparam int TICK_MS = 10;

  localparam int DUR_W   = 14;
  localparam int ROAD_W  = 10;
  localparam int REP_W   = 6;

  // Top modes
  localparam logic [1:0] MODE_INIT   = 2'd0;
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;
  localparam logic [1:0] MODE_SET    = 2'd3;

  // Road and set phases
  localparam logic [1:0] PH_INIT   = 2'd0;
  localparam logic [1:0] PH_RED    = 2'd1;
  localparam logic [1:0] PH_GREEN  = 2'd2;
  localparam logic [1:0] PH_YELLOW = 2'd3;

  // Manual phases
  localparam logic [2:0] MAN_INIT   = 3'd0;
  localparam logic [2:0] MAN_RED0   = 3'd1;
  localparam logic [2:0] MAN_RED1   = 3'd2;
  localparam logic [2:0] MAN_GREEN  = 3'd3;
  localparam logic [2:0] MAN_YELLOW = 3'd4;

  // Colour slots of the duration table
  localparam int COL_RED    = 0;
  localparam int COL_GREEN  = 1;
  localparam int COL_YELLOW = 2;

  // Lamp bit positions
  localparam int L1_RED = 0;
  localparam int L1_YEL = 1;
  localparam int L1_GRN = 2;
  localparam int L2_RED = 3;
  localparam int L2_YEL = 4;
  localparam int L2_GRN = 5;

  // Timer slots
  localparam int T_ROAD1 = 0;
  localparam int T_ROAD2 = 1;
  localparam int T_REP   = 2;

  // Configuration register indexes
  localparam logic REG_STEP  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [DUR_W-1:0] STEP_RST   = 14'd100;
  localparam logic [DUR_W-1:0] LIMIT_RST  = 14'd10000;
  localparam logic [DUR_W-1:0] RED_RST    = 14'd2000;
  localparam logic [DUR_W-1:0] GREEN_RST  = 14'd1200;
  localparam logic [DUR_W-1:0] YELLOW_RST = 14'd800;
  localparam logic [DUR_W-1:0] DUR_MAX    = 14'd16383;

  localparam logic [ROAD_W-1:0] ROAD_CNT_MAX = 10'd1023;
  localparam int REP_CNT_MAX = 63;

  // Repeat timer loads: first step after a press, then while held
  localparam int REP_FIRST_MS = 10;
  localparam int REP_HOLD_MS  = 500;
  localparam int REP_FIRST_RAW = REP_FIRST_MS / TICK_MS;
  localparam int REP_HOLD_RAW  = REP_HOLD_MS / TICK_MS;
  localparam logic [REP_W-1:0] REP_FIRST =
    (REP_FIRST_RAW > REP_CNT_MAX) ? 6'd63 : REP_W'(REP_FIRST_RAW);
  localparam logic [REP_W-1:0] REP_HOLD =
    (REP_HOLD_RAW > REP_CNT_MAX) ? 6'd63 : REP_W'(REP_HOLD_RAW);

  // ms / TICK_MS by reciprocal multiply; exact over the 14-bit range for TICK_MS <= 100
  localparam int DIV_SHIFT = 21;
  localparam int RECIP_W   = 22;
  localparam int PROD_W    = DUR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** DIV_SHIFT) + TICK_MS - 1) / TICK_MS);

  typedef struct packed {
    logic mode_press;
    logic next_press;
    logic adjust_press;
    logic adjust_held;
  } tlc_btn_t;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [1:0]                  r1ph;
    logic [1:0]                  r2ph;
    logic [2:0]                  mph;
    logic [1:0]                  sph;
    logic [5:0]                  lamps;
    logic [2:0][DUR_W-1:0]       dur;
    logic [ROAD_W-1:0]           cnt1;
    logic [ROAD_W-1:0]           cnt2;
    logic [REP_W-1:0]            rep;
    logic [2:0]                  flags;
  } tlc_state_t;

  localparam tlc_state_t STATE_RST = '{
    mode:  MODE_INIT,
    r1ph:  PH_INIT,
    r2ph:  PH_INIT,
    mph:   MAN_INIT,
    sph:   PH_INIT,
    lamps: 6'd0,
    dur:   {YELLOW_RST, GREEN_RST, RED_RST},
    cnt1:  '0,
    cnt2:  '0,
    rep:   '0,
    flags: 3'd0
  };

  // Road timer load value: ms / TICK_MS saturated to the counter range
  function automatic logic [ROAD_W-1:0] road_ticks(input logic [DUR_W-1:0] ms);
    logic [PROD_W-1:0] prod;
    logic [DUR_W-1:0]  q;
    prod = PROD_W'(ms) * PROD_W'(RECIP);
    q    = prod[DIV_SHIFT +: DUR_W];
    return (q > DUR_W'(ROAD_CNT_MAX)) ? ROAD_CNT_MAX : q[ROAD_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/tlc_next.sv
// Next-state logic for one tick: mode, phase machines, lamps, durations and timers.
`timescale 1ns / 1ps
`default_nettype none

module tlc_next (
  input  tlc_pkg::tlc_state_t            cur,
  input  tlc_pkg::tlc_btn_t              btn,
  input  logic [tlc_pkg::DUR_W-1:0]      step,
  input  logic [tlc_pkg::DUR_W-1:0]      limit,
  output tlc_pkg::tlc_state_t            nxt
);
  import tlc_pkg::*;

  logic [DUR_W-1:0]  r1_ms;
  logic [DUR_W-1:0]  r2_ms;
  logic [ROAD_W-1:0] r1_ticks;
  logic [ROAD_W-1:0] r2_ticks;
  logic [1:0]        col;
  logic [DUR_W:0]    sum;
  logic [DUR_W:0]    sum_wrap;
  logic [DUR_W-1:0]  sum_sat;
  logic              do_add;

  // Duration each road loads on leaving its current phase
  always_comb begin
    unique case (cur.r1ph)
      PH_INIT:   r1_ms = cur.dur[COL_RED];
      PH_RED:    r1_ms = cur.dur[COL_GREEN];
      PH_GREEN:  r1_ms = cur.dur[COL_YELLOW];
      PH_YELLOW: r1_ms = cur.dur[COL_RED];
    endcase
    unique case (cur.r2ph)
      PH_INIT:   r2_ms = cur.dur[COL_GREEN];
      PH_RED:    r2_ms = cur.dur[COL_GREEN];
      PH_GREEN:  r2_ms = cur.dur[COL_YELLOW];
      PH_YELLOW: r2_ms = cur.dur[COL_RED];
    endcase
  end

  assign r1_ticks = road_ticks(r1_ms);
  assign r2_ticks = road_ticks(r2_ms);

  // Colour selected in set mode and its adjusted duration
  always_comb begin
    unique case (cur.sph)
      PH_RED:   col = 2'(COL_RED);
      PH_GREEN: col = 2'(COL_GREEN);
      default:  col = 2'(COL_YELLOW);
    endcase
    sum      = {1'b0, cur.dur[col]} + {1'b0, step};
    sum_wrap = (sum > {1'b0, limit}) ? (sum - {1'b0, limit}) : sum;
    sum_sat  = (sum_wrap > {1'b0, DUR_MAX}) ? DUR_MAX : sum_wrap[DUR_W-1:0];
    // a press and a repeat expiry share one update, so at most one step per tick
    do_add   = btn.adjust_press || (btn.adjust_held && cur.flags[T_REP]);
  end

  always_comb begin
    nxt = cur;

    unique case (cur.mode)
      MODE_INIT: begin
        nxt.lamps = '0;
        nxt.mode  = MODE_AUTO;
      end

      MODE_AUTO: begin
        if (btn.mode_press) begin
          nxt.lamps = '0;
          nxt.mode  = MODE_MANUAL;
          if (cur.r1ph == PH_RED) begin
            if (cur.r2ph == PH_GREEN) begin
              nxt.mph = MAN_RED0;
            end else if (cur.r2ph == PH_YELLOW) begin
              nxt.mph = MAN_RED1;
            end
          end else if (cur.r1ph == PH_GREEN) begin
            nxt.mph = MAN_GREEN;
          end else if (cur.r1ph == PH_YELLOW) begin
            nxt.mph = MAN_YELLOW;
          end
        end else begin
          unique case (cur.r1ph)
            PH_INIT: begin
              nxt.r1ph = PH_RED;
              nxt.cnt1 = r1_ticks;
              nxt.flags[T_ROAD1] = 1'b0;
            end
            PH_RED: begin
              if (cur.flags[T_ROAD1]) begin
                nxt.r1ph = PH_GREEN;
                nxt.cnt1 = r1_ticks;
                nxt.flags[T_ROAD1] = 1'b0;
              end
              nxt.lamps[L1_RED] = 1'b1;
              nxt.lamps[L1_YEL] = 1'b0;
            end
            PH_GREEN: begin
              if (cur.flags[T_ROAD1]) begin
                nxt.r1ph = PH_YELLOW;
                nxt.cnt1 = r1_ticks;
                nxt.flags[T_ROAD1] = 1'b0;
              end
              nxt.lamps[L1_GRN] = 1'b1;
              nxt.lamps[L1_RED] = 1'b0;
            end
            PH_YELLOW: begin
              if (cur.flags[T_ROAD1]) begin
                nxt.r1ph = PH_RED;
                nxt.cnt1 = r1_ticks;
                nxt.flags[T_ROAD1] = 1'b0;
              end
              nxt.lamps[L1_YEL] = 1'b1;
              nxt.lamps[L1_GRN] = 1'b0;
            end
          endcase

          unique case (cur.r2ph)
            PH_INIT: begin
              nxt.r2ph = PH_GREEN;
              nxt.cnt2 = r2_ticks;
              nxt.flags[T_ROAD2] = 1'b0;
            end
            PH_RED: begin
              if (cur.flags[T_ROAD2]) begin
                nxt.r2ph = PH_GREEN;
                nxt.cnt2 = r2_ticks;
                nxt.flags[T_ROAD2] = 1'b0;
              end
              nxt.lamps[L2_RED] = 1'b1;
              nxt.lamps[L2_YEL] = 1'b0;
            end
            PH_GREEN: begin
              if (cur.flags[T_ROAD2]) begin
                nxt.r2ph = PH_YELLOW;
                nxt.cnt2 = r2_ticks;
                nxt.flags[T_ROAD2] = 1'b0;
              end
              nxt.lamps[L2_GRN] = 1'b1;
              nxt.lamps[L2_RED] = 1'b0;
            end
            PH_YELLOW: begin
              if (cur.flags[T_ROAD2]) begin
                nxt.r2ph = PH_RED;
                nxt.cnt2 = r2_ticks;
                nxt.flags[T_ROAD2] = 1'b0;
              end
              nxt.lamps[L2_YEL] = 1'b1;
              nxt.lamps[L2_GRN] = 1'b0;
            end
          endcase
        end
      end

      MODE_MANUAL: begin
        if (btn.mode_press) begin
          nxt.mode  = MODE_SET;
          nxt.sph   = PH_INIT;
          nxt.r1ph  = PH_INIT;
          nxt.r2ph  = PH_INIT;
          nxt.cnt1  = '0;
          nxt.cnt2  = '0;
          nxt.flags[T_ROAD1] = 1'b0;
          nxt.flags[T_ROAD2] = 1'b0;
          nxt.lamps = '0;
        end else begin
          unique case (cur.mph)
            MAN_INIT: begin
              nxt.lamps = '0;
              nxt.mph   = MAN_RED0;
            end
            MAN_RED0: begin
              if (btn.next_press) nxt.mph = MAN_RED1;
              nxt.lamps[L1_YEL] = 1'b0;
              nxt.lamps[L2_RED] = 1'b0;
              nxt.lamps[L1_RED] = 1'b1;
              nxt.lamps[L2_GRN] = 1'b1;
            end
            MAN_RED1: begin
              if (btn.next_press) nxt.mph = MAN_GREEN;
              nxt.lamps[L2_GRN] = 1'b0;
              nxt.lamps[L1_RED] = 1'b1;
              nxt.lamps[L2_YEL] = 1'b1;
            end
            MAN_GREEN: begin
              if (btn.next_press) nxt.mph = MAN_YELLOW;
              nxt.lamps[L1_RED] = 1'b0;
              nxt.lamps[L2_YEL] = 1'b0;
              nxt.lamps[L1_GRN] = 1'b1;
              nxt.lamps[L2_RED] = 1'b1;
            end
            MAN_YELLOW: begin
              if (btn.next_press) nxt.mph = MAN_RED0;
              nxt.lamps[L1_GRN] = 1'b0;
              nxt.lamps[L1_YEL] = 1'b1;
              nxt.lamps[L2_RED] = 1'b1;
            end
            default: begin
              // unreachable codes hold and drive nothing
            end
          endcase
        end
      end

      MODE_SET: begin
        if (btn.mode_press) begin
          nxt.mode  = MODE_AUTO;
          nxt.lamps = '0;
        end else if (cur.sph == PH_INIT) begin
          nxt.sph = PH_RED;
        end else begin
          unique case (cur.sph)
            PH_RED: begin
              if (btn.next_press) nxt.sph = PH_GREEN;
              nxt.lamps[L1_YEL] = 1'b0;
              nxt.lamps[L2_YEL] = 1'b0;
              nxt.lamps[L1_RED] = 1'b1;
              nxt.lamps[L2_RED] = 1'b1;
            end
            PH_GREEN: begin
              if (btn.next_press) nxt.sph = PH_YELLOW;
              nxt.lamps[L1_RED] = 1'b0;
              nxt.lamps[L2_RED] = 1'b0;
              nxt.lamps[L1_GRN] = 1'b1;
              nxt.lamps[L2_GRN] = 1'b1;
            end
            default: begin
              if (btn.next_press) nxt.sph = PH_RED;
              nxt.lamps[L1_GRN] = 1'b0;
              nxt.lamps[L2_GRN] = 1'b0;
              nxt.lamps[L1_YEL] = 1'b1;
              nxt.lamps[L2_YEL] = 1'b1;
            end
          endcase

          if (do_add) nxt.dur[col] = sum_sat;

          if (!btn.adjust_held) begin
            nxt.rep = '0;
            nxt.flags[T_REP] = 1'b0;
          end else if (btn.adjust_press) begin
            nxt.rep = REP_FIRST;
            nxt.flags[T_REP] = 1'b0;
          end else if (cur.flags[T_REP]) begin
            nxt.rep = REP_HOLD;
            nxt.flags[T_REP] = 1'b0;
          end
        end
      end
    endcase

    // End-of-tick countdown, every mode
    if (nxt.cnt1 != '0) begin
      nxt.cnt1 = nxt.cnt1 - ROAD_W'(1);
      if (nxt.cnt1 == '0) nxt.flags[T_ROAD1] = 1'b1;
    end
    if (nxt.cnt2 != '0) begin
      nxt.cnt2 = nxt.cnt2 - ROAD_W'(1);
      if (nxt.cnt2 == '0) nxt.flags[T_ROAD2] = 1'b1;
    end
    if (nxt.rep != '0) begin
      nxt.rep = nxt.rep - REP_W'(1);
      if (nxt.rep == '0) nxt.flags[T_REP] = 1'b1;
    end
  end

endmodule

`default_nettype wire

### src/two_road_traffic_light_controller_core.sv
// Two-road traffic light controller: top level with handshakes and state registers.
//
// Each input transfer is one timer tick carrying the four button events.
// Each tick yields exactly one result: the six lamps, the top mode and the
// three phase durations in ms as they stand after that tick.
// A result is valid in the cycle after its tick is transferred. Throughput
// is one tick per cycle while the receiver takes results; the state registers
// are updated through one pass of next-state logic, whose longest path is the
// duration-to-tick-count reciprocal multiply feeding a road timer.
// The state registers double as the result register, so a new tick is
// taken whenever no result is pending or the pending one is transferred in
// the same cycle. While the receiver stalls, the result holds and no tick
// is taken.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 step, 1 limit)
// in the same cycle; write only while idle.
// Reset (synchronous, rst high): init mode, all lamps off, durations
// 2000/1200/800 ms, timers clear, step 100, limit 10000, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module two_road_traffic_light_controller_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [tlc_pkg::DUR_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode_press,
  input  logic                         next_press,
  input  logic                         adjust_press,
  input  logic                         adjust_held,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         road1_red,
  output logic                         road1_yellow,
  output logic                         road1_green,
  output logic                         road2_red,
  output logic                         road2_yellow,
  output logic                         road2_green,
  output logic [1:0]                   top_mode,
  output logic [tlc_pkg::DUR_W-1:0]    red_ms,
  output logic [tlc_pkg::DUR_W-1:0]    green_ms,
  output logic [tlc_pkg::DUR_W-1:0]    yellow_ms
);
  import tlc_pkg::*;

  tlc_state_t       state;
  tlc_state_t       state_next;
  tlc_btn_t         btn;
  logic [DUR_W-1:0] step;
  logic [DUR_W-1:0] limit;
  logic             in_xfer;

  assign btn = '{mode_press:   mode_press,
                 next_press:   next_press,
                 adjust_press: adjust_press,
                 adjust_held:  adjust_held};

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  tlc_next u_next (
    .cur   (state),
    .btn   (btn),
    .step  (step),
    .limit (limit),
    .nxt   (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_RST;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= STEP_RST;
      limit <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP:  step  <= cfg_data;
        REG_LIMIT: limit <= cfg_data;
      endcase
    end
  end

  assign road1_red    = state.lamps[L1_RED];
  assign road1_yellow = state.lamps[L1_YEL];
  assign road1_green  = state.lamps[L1_GRN];
  assign road2_red    = state.lamps[L2_RED];
  assign road2_yellow = state.lamps[L2_YEL];
  assign road2_green  = state.lamps[L2_GRN];
  assign top_mode     = state.mode;
  assign red_ms       = state.dur[COL_RED];
  assign green_ms     = state.dur[COL_GREEN];
  assign yellow_ms    = state.dur[COL_YELLOW];

  // State only moves on a tick transfer
  assert property (@(posedge clk) disable iff (rst)
    !in_xfer |=> $stable(state))
    else $error("state changed without a tick transfer");

  // A tick transfer always leaves a result pending
  assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> out_valid)
    else $error("tick transferred but no result pending");

  // A raised timer flag means its count has run out
  assert property (@(posedge clk) disable iff (rst)
    (!state.flags[T_ROAD1] || state.cnt1 == '0) &&
    (!state.flags[T_ROAD2] || state.cnt2 == '0) &&
    (!state.flags[T_REP] || state.rep == '0))
    else $error("timer flag set with nonzero count");

  // Manual phase stays within its defined codes
  assert property (@(posedge clk) disable iff (rst)
    state.mph <= MAN_YELLOW)
    else $error("manual phase out of range");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Testbench for the two-road traffic light controller core: directed and random ticks.
`timescale 1ns / 1ps

module tb_top;
  import tlc_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [5:0]       lamps;
    logic [1:0]       mode;
    logic [DUR_W-1:0] red;
    logic [DUR_W-1:0] green;
    logic [DUR_W-1:0] yellow;
  } light_state_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_STEP;
  logic [DUR_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             mode_press = 1'b0;
  logic             next_press = 1'b0;
  logic             adjust_press = 1'b0;
  logic             adjust_held = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             road1_red, road1_yellow, road1_green;
  logic             road2_red, road2_yellow, road2_green;
  logic [1:0]       top_mode;
  logic [DUR_W-1:0] red_ms, green_ms, yellow_ms;

  two_road_traffic_light_controller_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode_press(mode_press), .next_press(next_press),
    .adjust_press(adjust_press), .adjust_held(adjust_held),
    .out_valid(out_valid), .out_ready(out_ready),
    .road1_red(road1_red), .road1_yellow(road1_yellow), .road1_green(road1_green),
    .road2_red(road2_red), .road2_yellow(road2_yellow), .road2_green(road2_green),
    .top_mode(top_mode), .red_ms(red_ms), .green_ms(green_ms), .yellow_ms(yellow_ms)
  );

  always #5 clk = ~clk;

  // controller state as predicted
  logic [1:0]        cur_mode, road1_ph, road2_ph, set_ph;
  logic [2:0]        man_ph;
  logic [5:0]        lamps;
  logic [DUR_W-1:0]  dur_ms [3];
  logic [ROAD_W-1:0] road_cnt [2];
  logic [REP_W-1:0]  rep_cnt;
  logic [2:0]        tflags;
  logic [DUR_W-1:0]  step_ms, limit_ms;

  light_state_t expected_lights [$];
  light_state_t want;

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_writes = 0;
  int stall_cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_tgl = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  bit adj_held_now = 1'b0;

  function automatic void reset_model();
    cur_mode = MODE_INIT;
    road1_ph = PH_INIT;
    road2_ph = PH_INIT;
    set_ph = PH_INIT;
    man_ph = MAN_INIT;
    lamps = '0;
    dur_ms[COL_RED] = RED_RST;
    dur_ms[COL_GREEN] = GREEN_RST;
    dur_ms[COL_YELLOW] = YELLOW_RST;
    road_cnt[0] = '0;
    road_cnt[1] = '0;
    rep_cnt = '0;
    tflags = '0;
    step_ms = STEP_RST;
    limit_ms = LIMIT_RST;
  endfunction

  function automatic void load_timer(input int slot, input int ms);
    int ticks;
    ticks = ms / TICK_MS;
    if (slot == T_REP) begin
      rep_cnt = REP_W'((ticks > REP_CNT_MAX) ? REP_CNT_MAX : ticks);
    end else begin
      road_cnt[slot] = ROAD_W'((ticks > int'(ROAD_CNT_MAX)) ? int'(ROAD_CNT_MAX) : ticks);
    end
    tflags[slot] = 1'b0;
  endfunction

  function automatic void count_down();
    for (int s = 0; s < 2; s++) begin
      if (road_cnt[s] != 0) begin
        road_cnt[s] = road_cnt[s] - 1'b1;
        if (road_cnt[s] == 0) tflags[s] = 1'b1;
      end
    end
    if (rep_cnt != 0) begin
      rep_cnt = rep_cnt - 1'b1;
      if (rep_cnt == 0) tflags[T_REP] = 1'b1;
    end
  endfunction

  // sum past the limit wraps once, then clamps to the field
  function automatic void bump_duration(input int c);
    int sum;
    sum = int'(dur_ms[c]) + int'(step_ms);
    if (sum > int'(limit_ms)) sum -= int'(limit_ms);
    if (sum > int'(DUR_MAX)) sum = int'(DUR_MAX);
    dur_ms[c] = DUR_W'(sum);
  endfunction

  function automatic logic [1:0] road_next(input logic [1:0] ph, input int slot,
                                           input int rb, input int yb, input int gb,
                                           input logic [1:0] first);
    logic [1:0] nx;
    nx = ph;
    case (ph)
      PH_INIT: begin
        nx = first;
        load_timer(slot, dur_ms[(first == PH_RED) ? COL_RED : COL_GREEN]);
      end
      PH_RED: begin
        if (tflags[slot]) begin
          nx = PH_GREEN;
          load_timer(slot, dur_ms[COL_GREEN]);
        end
        lamps[rb] = 1'b1;
        lamps[yb] = 1'b0;
      end
      PH_GREEN: begin
        if (tflags[slot]) begin
          nx = PH_YELLOW;
          load_timer(slot, dur_ms[COL_YELLOW]);
        end
        lamps[gb] = 1'b1;
        lamps[rb] = 1'b0;
      end
      default: begin
        if (tflags[slot]) begin
          nx = PH_RED;
          load_timer(slot, dur_ms[COL_RED]);
        end
        lamps[yb] = 1'b1;
        lamps[gb] = 1'b0;
      end
    endcase
    return nx;
  endfunction

  function automatic void manual_step(input logic nxt);
    case (man_ph)
      MAN_INIT: begin
        lamps = '0;
        man_ph = MAN_RED0;
      end
      MAN_RED0: begin
        if (nxt) man_ph = MAN_RED1;
        lamps[L1_YEL] = 1'b0; lamps[L2_RED] = 1'b0;
        lamps[L1_RED] = 1'b1; lamps[L2_GRN] = 1'b1;
      end
      MAN_RED1: begin
        if (nxt) man_ph = MAN_GREEN;
        lamps[L2_GRN] = 1'b0;
        lamps[L1_RED] = 1'b1; lamps[L2_YEL] = 1'b1;
      end
      MAN_GREEN: begin
        if (nxt) man_ph = MAN_YELLOW;
        lamps[L1_RED] = 1'b0; lamps[L2_YEL] = 1'b0;
        lamps[L1_GRN] = 1'b1; lamps[L2_RED] = 1'b1;
      end
      MAN_YELLOW: begin
        if (nxt) man_ph = MAN_RED0;
        lamps[L1_GRN] = 1'b0;
        lamps[L1_YEL] = 1'b1; lamps[L2_RED] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void set_step(input tlc_btn_t b);
    int c, offa, offb, on1, on2;
    if (set_ph == PH_INIT) begin
      set_ph = PH_RED;
    end else begin
      case (set_ph)
        PH_RED: begin
          c = COL_RED; offa = L1_YEL; offb = L2_YEL; on1 = L1_RED; on2 = L2_RED;
          if (b.next_press) set_ph = PH_GREEN;
        end
        PH_GREEN: begin
          c = COL_GREEN; offa = L1_RED; offb = L2_RED; on1 = L1_GRN; on2 = L2_GRN;
          if (b.next_press) set_ph = PH_YELLOW;
        end
        default: begin
          c = COL_YELLOW; offa = L1_GRN; offb = L2_GRN; on1 = L1_YEL; on2 = L2_YEL;
          if (b.next_press) set_ph = PH_RED;
        end
      endcase
      lamps[offa] = 1'b0; lamps[offb] = 1'b0;
      lamps[on1] = 1'b1; lamps[on2] = 1'b1;
      if (b.adjust_press) begin
        bump_duration(c);
        load_timer(T_REP, REP_FIRST_MS);
      end
      if (b.adjust_held) begin
        if (tflags[T_REP]) begin
          bump_duration(c);
          load_timer(T_REP, REP_HOLD_MS);
        end
      end else begin
        rep_cnt = '0;
        tflags[T_REP] = 1'b0;
      end
    end
  endfunction

  function automatic light_state_t advance_tick(input tlc_btn_t b);
    light_state_t r;
    case (cur_mode)
      MODE_INIT: begin
        lamps = '0;
        cur_mode = MODE_AUTO;
      end
      MODE_AUTO: begin
        if (b.mode_press) begin
          lamps = '0;
          cur_mode = MODE_MANUAL;
          // carry the road picture over into the manual pattern
          if (road1_ph == PH_RED) begin
            if (road2_ph == PH_GREEN) man_ph = MAN_RED0;
            else if (road2_ph == PH_YELLOW) man_ph = MAN_RED1;
          end else if (road1_ph == PH_GREEN) begin
            man_ph = MAN_GREEN;
          end else if (road1_ph == PH_YELLOW) begin
            man_ph = MAN_YELLOW;
          end
        end else begin
          road1_ph = road_next(road1_ph, T_ROAD1, L1_RED, L1_YEL, L1_GRN, PH_RED);
          road2_ph = road_next(road2_ph, T_ROAD2, L2_RED, L2_YEL, L2_GRN, PH_GREEN);
        end
      end
      MODE_MANUAL: begin
        if (b.mode_press) begin
          cur_mode = MODE_SET;
          set_ph = PH_INIT;
          road1_ph = PH_INIT;
          road2_ph = PH_INIT;
          road_cnt[0] = '0;
          road_cnt[1] = '0;
          tflags[T_ROAD1] = 1'b0;
          tflags[T_ROAD2] = 1'b0;
          lamps = '0;
        end else begin
          manual_step(b.next_press);
        end
      end
      default: begin
        if (b.mode_press) begin
          cur_mode = MODE_AUTO;
          lamps = '0;
        end else begin
          set_step(b);
        end
      end
    endcase
    count_down();
    r.lamps = lamps;
    r.mode = cur_mode;
    r.red = dur_ms[COL_RED];
    r.green = dur_ms[COL_GREEN];
    r.yellow = dur_ms[COL_YELLOW];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [DUR_W-1:0] want_v,
                                      input logic [DUR_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  // scoreboard, predictor and watchdog, all on the sampled edge
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lights.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = expected_lights.pop_front();
          check_field("road1_red", want.lamps[L1_RED], road1_red);
          check_field("road1_yellow", want.lamps[L1_YEL], road1_yellow);
          check_field("road1_green", want.lamps[L1_GRN], road1_green);
          check_field("road2_red", want.lamps[L2_RED], road2_red);
          check_field("road2_yellow", want.lamps[L2_YEL], road2_yellow);
          check_field("road2_green", want.lamps[L2_GRN], road2_green);
          check_field("top_mode", want.mode, top_mode);
          check_field("red_ms", want.red, red_ms);
          check_field("green_ms", want.green, green_ms);
          check_field("yellow_ms", want.yellow, yellow_ms);
          n_checked++;
        end
      end
      if (in_valid && in_ready) begin
        expected_lights.push_back(advance_tick({mode_press, next_press,
                                                adjust_press, adjust_held}));
        n_sent++;
      end
      if (cfg_we) begin
        if (cfg_index == REG_STEP) step_ms = cfg_data;
        else limit_ms = cfg_data;
        n_writes++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic tlc_btn_t btns(input logic m, input logic n, input logic a,
                                    input logic h);
    tlc_btn_t b;
    b.mode_press = m;
    b.next_press = n;
    b.adjust_press = a;
    b.adjust_held = h;
    return b;
  endfunction

  task automatic send_tick(input tlc_btn_t b);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    mode_press <= b.mode_press;
    next_press <= b.next_press;
    adjust_press <= b.adjust_press;
    adjust_held <= b.adjust_held;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_lights.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input int val);
    wait_results_done();
    cfg_index <= idx;
    cfg_data <= DUR_W'(val);
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic goto_mode(input logic [1:0] target);
    wait_results_done();
    while (cur_mode != target) begin
      send_tick(btns(1'b1, 1'b0, 1'b0, 1'b0));
      wait_results_done();
    end
  endtask

  // steer one colour's duration to a target through adjust presses, limit at 10000
  task automatic set_duration(input int c, input int target);
    logic [1:0] ph;
    int d, stp;
    ph = (c == COL_RED) ? PH_RED : (c == COL_GREEN) ? PH_GREEN : PH_YELLOW;
    write_reg(REG_LIMIT, 10000);
    goto_mode(MODE_SET);
    while (set_ph != ph) begin
      send_tick(btns(1'b0, 1'b1, 1'b0, 1'b0));
      wait_results_done();
    end
    while (int'(dur_ms[c]) != target) begin
      d = int'(dur_ms[c]);
      if (target > d && target - d >= 10) stp = target - d;
      else if (target + 10000 - d >= 10 && target + 10000 - d <= 10000) stp = target + 10000 - d;
      else stp = 10;
      write_reg(REG_STEP, stp);
      send_tick(btns(1'b0, 1'b0, 1'b1, 1'b0));
      wait_results_done();
    end
  endtask

  task automatic run_random(input int n_ticks, input bit allow_mode);
    tlc_btn_t b;
    int odds;
    for (int i = 0; i < n_ticks; i++) begin
      b = '0;
      // held stretches start with a real press
      if (adj_held_now) begin
        if ($urandom_range(79) == 0) adj_held_now = 1'b0;
      end else if ($urandom_range(59) == 0) begin
        adj_held_now = 1'b1;
        b.adjust_press = 1'b1;
      end
      b.adjust_held = adj_held_now;
      if ($urandom_range(11) == 0) b.adjust_press = 1'b1;
      if ($urandom_range(29) == 0) b.adjust_held = ~b.adjust_held;
      b.next_press = ($urandom_range(7) == 0);
      case (cur_mode)
        MODE_AUTO: odds = 160;
        MODE_MANUAL: odds = 40;
        default: odds = 60;
      endcase
      b.mode_press = allow_mode && ($urandom_range(odds - 1) == 0);
      send_tick(b);
    end
  endtask

  task automatic test_mode_walk();
    send_tick(btns(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(btns(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(btns(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(btns(1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(btns(1'b0, 1'b0, 1'b0, 1'b0));
    repeat (4) send_tick(btns(1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(btns(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(btns(1'b1, 1'b1, 1'b1, 1'b0));
    send_tick(btns(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(btns(1'b0, 1'b0, 1'b1, 1'b1));
    send_tick(btns(1'b0, 1'b0, 1'b0, 1'b1));
    send_tick(btns(1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(btns(1'b0, 1'b0, 1'b1, 1'b0));
    send_tick(btns(1'b0, 1'b1, 1'b1, 1'b0));
    send_tick(btns(1'b0, 1'b0, 1'b1, 1'b1));
    send_tick(btns(1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(btns(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(btns(1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_duration_limits();
    set_duration(COL_GREEN, 9999);
    // wrap by a tiny limit still lands above the field range: clamps
    write_reg(REG_LIMIT, 100);
    write_reg(REG_STEP, 10000);
    send_tick(btns(1'b0, 1'b0, 1'b1, 1'b0));
    // red under one tick: its timer loads zero and never expires
    set_duration(COL_RED, 5);
    // green load saturates the road counter; a truncated load would end it early
    goto_mode(MODE_AUTO);
    run_random(650, 1'b0);
    set_duration(COL_RED, 300);
    set_duration(COL_GREEN, 200);
    set_duration(COL_YELLOW, 100);
  endtask

  task automatic test_backpressure();
    hold_tgl <= ~hold_tgl;
    run_random(30, 1'b1);
    wait_results_done();
  endtask

  task automatic test_random_traffic();
    write_reg(REG_STEP, $urandom_range(300, 10));
    write_reg(REG_LIMIT, $urandom_range(1500, 200));
    run_random(250, 1'b1);
    tx_idle_pct = 55;
    rx_idle_pct = 16;
    write_reg(REG_STEP, 10);
    write_reg(REG_LIMIT, 100);
    run_random(250, 1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_STEP, 10000);
    write_reg(REG_LIMIT, 10000);
    run_random(60, 1'b1);
    write_reg(REG_STEP, $urandom_range(300, 10));
    write_reg(REG_LIMIT, $urandom_range(1500, 200));
    run_random(180, 1'b1);
  endtask

  initial begin
    tx_idle_pct = 16;
    rx_idle_pct = 55;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_mode_walk();
    test_duration_limits();
    test_backpressure();
    test_random_traffic();
    wait_results_done();
    repeat (5) @(posedge clk);
    $display("summary: %0d tick transfers, %0d results checked, %0d register writes",
             n_sent, n_checked, n_writes);
    $display("summary: all modes, wrap and clamp of durations, zero and saturated loads");
    if (errors == 0 && expected_lights.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
